>>> hw/rtl/ocp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocp_pkg
// Shared constants, state encoding and memory request type of the order
// crossover block.
// ----------------------------------------------------------------------------
package ocp_pkg;

    localparam int MAX_LENGTH   = 64;
    localparam int ELEMENT_BITS = 8;
    localparam int CUT_W        = 7;
    localparam int CNT_W        = $clog2(MAX_LENGTH + 1);
    localparam int ADDR_W       = $clog2(MAX_LENGTH);
    localparam int POS_W        = (CNT_W > CUT_W) ? CNT_W : CUT_W;
    localparam int MARK_DEPTH   = 1 << ELEMENT_BITS;
    localparam int CFG_IDX_W    = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CUT_FIRST  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CUT_SECOND = CFG_IDX_W'(1);

    localparam logic [CUT_W-1:0] CUT_FIRST_RESET  = CUT_W'(11);
    localparam logic [CUT_W-1:0] CUT_SECOND_RESET = CUT_W'(1);

    localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_LENGTH);

    typedef enum logic [3:0] {
        S_INIT,
        S_LOAD,
        S_SETUP,
        S_MARK,
        S_FILL,
        S_SCAN_MARK,
        S_SCAN_DECIDE,
        S_SLICE,
        S_SLICE_EMIT,
        S_CLEAR
    } state_t;

    typedef struct packed {
        logic                    par_re;
        logic                    par_we;
        logic [ADDR_W-1:0]       par_addr;
        logic                    mark_re;
        logic                    mark_we;
        logic [ELEMENT_BITS-1:0] mark_waddr;
        logic                    mark_wdata;
        logic [ELEMENT_BITS-1:0] mark_raddr;
    } mem_req_t;

endpackage
`default_nettype wire

>>> hw/rtl/ocp_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocp_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ocp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

>>> hw/rtl/ocp_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ocp_ctrl
// Sequencer: loads parents, marks the slice, streams the child in position
// order through an output register and clears the marks afterwards.
// ----------------------------------------------------------------------------
module ocp_ctrl (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              last_pair,
    input  wire logic                              cfg_we,
    input  wire logic [ocp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ocp_pkg::CUT_W-1:0]         cfg_data,
    input  wire logic [ocp_pkg::ELEMENT_BITS-1:0]  first_rdata,
    input  wire logic [ocp_pkg::ELEMENT_BITS-1:0]  second_rdata,
    input  wire logic                              mark_rdata,
    output ocp_pkg::mem_req_t                      mem_req,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic      [ocp_pkg::ELEMENT_BITS-1:0]  child_element,
    output logic                                   last_child
);

    import ocp_pkg::*;

    state_t                  state_reg, state_next;
    logic [CUT_W-1:0]        cut_first_reg, cut_second_reg;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CNT_W-1:0]        n_reg, n_next;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic                    swap_reg, swap_next;
    logic                    back_reg, back_next;
    logic                    pend_reg, pend_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;
    logic [CNT_W-1:0]        scan_reg, scan_next;
    logic [CNT_W-1:0]        fill_reg, fill_next;
    logic [CNT_W-1:0]        emit_cnt_reg, emit_cnt_next;
    logic [ELEMENT_BITS-1:0] init_cnt_reg, init_cnt_next;
    logic                    out_valid_reg, out_valid_next;
    logic [ELEMENT_BITS-1:0] child_reg, child_next;
    logic                    last_reg, last_next;

    logic                    accept;
    logic                    out_free;
    logic                    emit;
    logic [ELEMENT_BITS-1:0] emit_data;
    logic [ELEMENT_BITS-1:0] keep_rdata, donor_rdata;
    logic [POS_W-1:0]        cf_ext, cs_ext, n_ext;
    logic [CNT_W-1:0]        cut_a, cut_b;
    logic [CNT_W-1:0]        need;

    assign accept      = in_valid && !in_stall;
    assign out_free    = !out_valid_reg || !out_stall;
    assign keep_rdata  = swap_reg ? second_rdata : first_rdata;
    assign donor_rdata = swap_reg ? first_rdata : second_rdata;
    assign need        = back_reg ? (n_reg - hi_reg) : lo_reg;

    // cut clamping to the loaded length
    assign cf_ext = POS_W'(cut_first_reg);
    assign cs_ext = POS_W'(cut_second_reg);
    assign n_ext  = POS_W'(n_reg);
    assign cut_a  = (cf_ext < n_ext) ? cf_ext[CNT_W-1:0] : n_reg;
    assign cut_b  = (cs_ext < n_ext) ? cs_ext[CNT_W-1:0] : n_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cut_first_reg  <= CUT_FIRST_RESET;
            cut_second_reg <= CUT_SECOND_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CUT_FIRST:  cut_first_reg  <= cfg_data;
                REG_CUT_SECOND: cut_second_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            count_reg     <= '0;
            back_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            init_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            back_reg      <= back_next;
            pend_reg      <= pend_next;
            init_cnt_reg  <= init_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        swap_reg     <= swap_next;
        idx_reg      <= idx_next;
        scan_reg     <= scan_next;
        fill_reg     <= fill_next;
        emit_cnt_reg <= emit_cnt_next;
        child_reg    <= child_next;
        last_reg     <= last_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        n_next        = n_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        swap_next     = swap_reg;
        back_next     = back_reg;
        pend_next     = pend_reg;
        idx_next      = idx_reg;
        scan_next     = scan_reg;
        fill_next     = fill_reg;
        emit_cnt_next = emit_cnt_reg;
        init_cnt_next = init_cnt_reg;
        in_stall      = 1'b1;
        emit          = 1'b0;
        emit_data     = '0;
        mem_req       = '0;

        unique case (state_reg) inside
            S_INIT:
            begin
                // clearing pass over the whole mark store after reset
                mem_req.mark_we    = 1'b1;
                mem_req.mark_waddr = init_cnt_reg;
                mem_req.mark_wdata = 1'b0;
                init_cnt_next      = init_cnt_reg + ELEMENT_BITS'(1);
                if (init_cnt_reg == '1)
                begin
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                in_stall         = 1'b0;
                mem_req.par_addr = count_reg[ADDR_W-1:0];
                if (accept)
                begin
                    if (count_reg < MAX_COUNT)
                    begin
                        mem_req.par_we = 1'b1;
                        count_next     = count_reg + CNT_W'(1);
                    end
                    if (last_pair)
                    begin
                        n_next     = (count_reg < MAX_COUNT) ? count_reg + CNT_W'(1)
                                                             : MAX_COUNT;
                        count_next = '0;
                        state_next = S_SETUP;
                    end
                end
            end

            S_SETUP:
            begin
                swap_next     = !(cut_a < cut_b);
                lo_next       = (cut_a < cut_b) ? cut_a : cut_b;
                hi_next       = (cut_a < cut_b) ? cut_b : cut_a;
                idx_next      = (cut_a < cut_b) ? cut_a : cut_b;
                pend_next     = 1'b0;
                emit_cnt_next = '0;
                state_next    = S_MARK;
            end

            S_MARK, S_CLEAR:
            begin
                // read keep[idx] and write its mark in the following cycle
                mem_req.mark_we    = pend_reg;
                mem_req.mark_waddr = keep_rdata;
                mem_req.mark_wdata = (state_reg == S_MARK);
                if (idx_reg < hi_reg)
                begin
                    mem_req.par_re   = 1'b1;
                    mem_req.par_addr = idx_reg[ADDR_W-1:0];
                    idx_next         = idx_reg + CNT_W'(1);
                    pend_next        = 1'b1;
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        if (state_reg == S_MARK)
                        begin
                            back_next  = 1'b0;
                            fill_next  = '0;
                            scan_next  = '0;
                            state_next = S_FILL;
                        end
                        else
                        begin
                            state_next = S_LOAD;
                        end
                    end
                end
            end

            S_FILL:
            begin
                if (fill_reg == need)
                begin
                    if (back_reg)
                    begin
                        idx_next   = lo_reg;
                        pend_next  = 1'b0;
                        state_next = S_CLEAR;
                    end
                    else
                    begin
                        idx_next   = lo_reg;
                        state_next = S_SLICE;
                    end
                end
                else if (scan_reg == n_reg)
                begin
                    // donor used up: remaining fill positions read zero
                    if (out_free)
                    begin
                        emit      = 1'b1;
                        fill_next = fill_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    mem_req.par_re   = 1'b1;
                    mem_req.par_addr = scan_reg[ADDR_W-1:0];
                    state_next       = S_SCAN_MARK;
                end
            end

            S_SCAN_MARK:
            begin
                mem_req.mark_re    = 1'b1;
                mem_req.mark_raddr = donor_rdata;
                state_next         = S_SCAN_DECIDE;
            end

            S_SCAN_DECIDE:
            begin
                if (mark_rdata)
                begin
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_FILL;
                end
                else if (out_free)
                begin
                    emit       = 1'b1;
                    emit_data  = donor_rdata;
                    fill_next  = fill_reg + CNT_W'(1);
                    scan_next  = scan_reg + CNT_W'(1);
                    state_next = S_FILL;
                end
            end

            S_SLICE:
            begin
                if (idx_reg == hi_reg)
                begin
                    back_next  = 1'b1;
                    fill_next  = '0;
                    state_next = S_FILL;
                end
                else
                begin
                    mem_req.par_re   = 1'b1;
                    mem_req.par_addr = idx_reg[ADDR_W-1:0];
                    state_next       = S_SLICE_EMIT;
                end
            end

            S_SLICE_EMIT:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    emit_data  = keep_rdata;
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_SLICE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase

        if (emit)
        begin
            emit_cnt_next = emit_cnt_reg + CNT_W'(1);
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        child_next     = child_reg;
        last_next      = last_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
            child_next     = emit_data;
            last_next      = ((emit_cnt_reg + CNT_W'(1)) == n_reg);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign child_element = child_reg;
    assign last_child    = last_reg;

endmodule
`default_nettype wire

>>> hw/rtl/order_crossover_permutation_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// order_crossover_permutation_top
// Order crossover of two loaded parent permutations, child streamed out.
// ----------------------------------------------------------------------------
// loading: one parent pair per cycle while no crossover is running
// crossover: the donor scan takes each donor element by a parent read, then a mark read,
//   then emits it unless it is marked as part of the slice
// reset: clearing pass over the whole mark store, no request taken then
module order_crossover_permutation_top (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [ocp_pkg::ELEMENT_BITS-1:0] crow_element,
    input  wire logic [ocp_pkg::ELEMENT_BITS-1:0] victim_element,
    input  wire logic                             last_pair,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic      [ocp_pkg::ELEMENT_BITS-1:0] child_element,
    output logic                                  last_child,
    input  wire logic                             cfg_we,
    input  wire logic [ocp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ocp_pkg::CUT_W-1:0]        cfg_data
);

    import ocp_pkg::*;

    mem_req_t                mem_req;
    logic [ELEMENT_BITS-1:0] first_rdata;
    logic [ELEMENT_BITS-1:0] second_rdata;
    logic [0:0]              mark_rdata;
    logic [0:0]              mark_wdata;

    assign mark_wdata = mem_req.mark_wdata;

    ocp_ram #(
        .DEPTH(MAX_LENGTH),
        .WIDTH(ELEMENT_BITS)
    ) u_first_ram (
        .clk   (clk),
        .we    (mem_req.par_we),
        .waddr (mem_req.par_addr),
        .wdata (crow_element),
        .re    (mem_req.par_re),
        .raddr (mem_req.par_addr),
        .rdata (first_rdata)
    );

    ocp_ram #(
        .DEPTH(MAX_LENGTH),
        .WIDTH(ELEMENT_BITS)
    ) u_second_ram (
        .clk   (clk),
        .we    (mem_req.par_we),
        .waddr (mem_req.par_addr),
        .wdata (victim_element),
        .re    (mem_req.par_re),
        .raddr (mem_req.par_addr),
        .rdata (second_rdata)
    );

    ocp_ram #(
        .DEPTH(MARK_DEPTH),
        .WIDTH(1)
    ) u_mark_ram (
        .clk   (clk),
        .we    (mem_req.mark_we),
        .waddr (mem_req.mark_waddr),
        .wdata (mark_wdata),
        .re    (mem_req.mark_re),
        .raddr (mem_req.mark_raddr),
        .rdata (mark_rdata)
    );

    ocp_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .last_pair     (last_pair),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .first_rdata   (first_rdata),
        .second_rdata  (second_rdata),
        .mark_rdata    (mark_rdata[0]),
        .mem_req       (mem_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .child_element (child_element),
        .last_child    (last_child)
    );

endmodule
`default_nettype wire
